@@ src/hcb_pkg.sv @@
package hcb_pkg;

   localparam int MAX_SYMBOLS_DEF = 32;
   localparam int COUNT_BITS_DEF  = 16;
   localparam int QUEUE_DEPTH     = 2;
   localparam int SYM_W  = 8;
   localparam int FREQ_W = 16;
   localparam int CODE_W = 31;
   localparam int LEN_W  = 5;

   // One counted request handed from the front to the back
   typedef struct packed {
      logic [SYM_W-1:0] symbol;
      logic             last;
   } item_type;

endpackage

@@ src/huffman_code_builder_unit.sv @@
// Channel | Ports                                         | Direction
// req     | req_valid req_stall req_symbol req_last       | in
// rsp     | rsp_valid rsp_stall rsp_code_symbol ...       | out
// Counting goes at one request per cycle; the front queue absorbs requests meanwhile.
// After a last request the back frees all nodes, then makes n-1 joins: the k-th scans
// n+k-1 nodes one per cycle and then joins the two lightest. Each symbol then walks up
// from its leaf to the root and emits its code; a lone symbol only emits.
// Reset is synchronous and clears control state only.
// A stalled result holds in the output register; building waits behind it.
module huffman_code_builder_unit #(
   parameter int MAX_SYMBOLS = hcb_pkg::MAX_SYMBOLS_DEF,
   parameter int COUNT_BITS  = hcb_pkg::COUNT_BITS_DEF,
   parameter int QUEUE_DEPTH = hcb_pkg::QUEUE_DEPTH
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [hcb_pkg::SYM_W-1:0]  req_symbol,
   input  logic                       req_last,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [hcb_pkg::SYM_W-1:0]  rsp_code_symbol,
   output logic [hcb_pkg::FREQ_W-1:0] rsp_frequency,
   output logic [hcb_pkg::CODE_W-1:0] rsp_code_bits,
   output logic [hcb_pkg::LEN_W-1:0]  rsp_code_length,
   output logic                       rsp_table_full,
   output logic                       rsp_last_code
);
   logic q_valid, q_pop;
   hcb_pkg::item_type q_item;

   hcb_front #(.DEPTH(QUEUE_DEPTH)) u_front (
      .clock, .reset, .req_valid, .req_stall, .req_symbol, .req_last,
      .q_valid, .q_pop, .q_item
   );

   hcb_back #(.MAX_SYMBOLS(MAX_SYMBOLS), .COUNT_BITS(COUNT_BITS)) u_back (
      .clock, .reset, .q_valid, .q_pop, .q_item,
      .rsp_valid, .rsp_stall, .rsp_code_symbol, .rsp_frequency, .rsp_code_bits,
      .rsp_code_length, .rsp_table_full, .rsp_last_code
   );
endmodule

@@ src/hcb_front.sv @@
module hcb_front #(
   parameter int DEPTH = hcb_pkg::QUEUE_DEPTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [hcb_pkg::SYM_W-1:0] req_symbol,
   input  logic                   req_last,
   output logic                   q_valid,
   input  logic                   q_pop,
   output hcb_pkg::item_type      q_item
);
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   hcb_pkg::item_type mem_ff [DEPTH];
   logic [AW-1:0] wp_ff, wp_in, rp_ff, rp_in;
   logic [AW:0]   cnt_ff, cnt_in;
   logic push;

   assign req_stall = (cnt_ff == (AW+1)'(DEPTH));
   assign push      = req_valid && !req_stall;
   assign q_valid   = (cnt_ff != '0);
   assign q_item    = mem_ff[rp_ff];

   // Advance the queue pointers
   always_comb begin
      wp_in  = wp_ff;
      rp_in  = rp_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wp_in = (wp_ff == AW'(DEPTH-1)) ? '0 : wp_ff + 1'b1;
      end
      if (q_pop && q_valid) begin
         rp_in = (rp_ff == AW'(DEPTH-1)) ? '0 : rp_ff + 1'b1;
      end
      cnt_in = cnt_ff + (AW+1)'(push) - (AW+1)'(q_pop && q_valid);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   // Store the request
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wp_ff] <= '{symbol: req_symbol, last: req_last};
      end
   end
endmodule

@@ src/hcb_back.sv @@
module hcb_back #(
   parameter int MAX_SYMBOLS = hcb_pkg::MAX_SYMBOLS_DEF,
   parameter int COUNT_BITS  = hcb_pkg::COUNT_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        q_valid,
   output logic                        q_pop,
   input  hcb_pkg::item_type           q_item,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [hcb_pkg::SYM_W-1:0]   rsp_code_symbol,
   output logic [hcb_pkg::FREQ_W-1:0]  rsp_frequency,
   output logic [hcb_pkg::CODE_W-1:0]  rsp_code_bits,
   output logic [hcb_pkg::LEN_W-1:0]   rsp_code_length,
   output logic                        rsp_table_full,
   output logic                        rsp_last_code
);
   localparam int NI    = MAX_SYMBOLS - 1;
   localparam int SW    = $clog2(MAX_SYMBOLS);
   localparam int DW    = $clog2(MAX_SYMBOLS + 1);
   localparam int WW    = COUNT_BITS + $clog2(MAX_SYMBOLS) + 1;
   localparam logic [COUNT_BITS-1:0] CMAX = '1;

   typedef enum logic [6:0] {
      ST_COUNT = 7'b0000001,
      ST_LOAD  = 7'b0000010,
      ST_SCAN  = 7'b0000100,
      ST_JOIN  = 7'b0001000,
      ST_WALK  = 7'b0010000,
      ST_EMIT  = 7'b0100000,
      ST_DONE  = 7'b1000000
   } state_type;

   state_type st_ff;

   logic [hcb_pkg::SYM_W-1:0] sym_ff [MAX_SYMBOLS];
   logic [COUNT_BITS-1:0]     cnt_ff [MAX_SYMBOLS];
   logic [DW-1:0]             dist_ff;
   logic                      ovf_ff;

   // Leaves are the table entries; joined nodes are numbered from zero in build order
   logic [WW-1:0]          iwt_ff  [NI];
   logic [SW-1:0]          lpar_ff [MAX_SYMBOLS];
   logic [SW-1:0]          ipar_ff [NI];
   logic                   lisr_ff [MAX_SYMBOLS];
   logic                   iisr_ff [NI];
   logic [MAX_SYMBOLS-1:0] lused_ff;
   logic [NI-1:0]          iused_ff;

   logic [SW-1:0] nxt_ff;         // joined node being built
   logic          sint_ff;        // scan is among joined nodes
   logic [SW-1:0] idx_ff;         // scan index
   logic [SW-1:0] a_ff, b_ff;     // best and second best
   logic          ai_ff, bi_ff;
   logic [WW-1:0] aw_ff, bw_ff;
   logic          ha_ff, hb_ff;
   logic [SW-1:0] sel_ff;         // symbol being emitted
   logic [SW-1:0] cur_ff;         // walk position
   logic          ci_ff;
   logic [hcb_pkg::CODE_W-1:0] code_ff;
   logic [5:0]    len_ff;

   // Output register
   logic ov_ff, ov_in;
   logic [hcb_pkg::SYM_W-1:0]  o_sym_ff;
   logic [hcb_pkg::FREQ_W-1:0] o_frq_ff;
   logic [hcb_pkg::CODE_W-1:0] o_code_ff;
   logic [hcb_pkg::LEN_W-1:0]  o_len_ff;
   logic o_full_ff, o_last_ff;

   assign rsp_valid       = ov_ff;
   assign rsp_code_symbol = o_sym_ff;
   assign rsp_frequency   = o_frq_ff;
   assign rsp_code_bits   = o_code_ff;
   assign rsp_code_length = o_len_ff;
   assign rsp_table_full  = o_full_ff;
   assign rsp_last_code   = o_last_ff;

   // Match the symbol against the table
   logic          hit;
   logic [SW-1:0] hit_idx;
   always_comb begin
      hit = 1'b0;
      hit_idx = '0;
      for (int i = 0; i < MAX_SYMBOLS; i++) begin
         if (!hit && (DW'(i) < dist_ff) && sym_ff[i] == q_item.symbol) begin
            hit = 1'b1;
            hit_idx = SW'(i);
         end
      end
   end

   assign q_pop = (st_ff == ST_COUNT) && q_valid;

   logic out_free;
   assign out_free = !ov_ff || !rsp_stall;

   // Drop the result once taken, load it on emit
   always_comb begin
      ov_in = ov_ff && rsp_stall;
      if (st_ff == ST_EMIT && out_free) ov_in = 1'b1;
   end

   // Weight and free flag of the scanned node
   logic [WW-1:0] swt;
   logic          sfree;
   always_comb begin
      if (sint_ff) begin
         swt   = iwt_ff[idx_ff];
         sfree = !iused_ff[idx_ff];
      end else begin
         swt   = WW'(cnt_ff[idx_ff]);
         sfree = !lused_ff[idx_ff];
      end
   end

   logic leaf_end, int_end;
   assign leaf_end = !sint_ff && (DW'(idx_ff) + 1'b1 == dist_ff);
   assign int_end  = sint_ff && (idx_ff + 1'b1 == nxt_ff);

   // Parent and side of the walk position
   logic [SW-1:0] cpar;
   logic          cisr;
   logic          at_root;
   always_comb begin
      if (ci_ff) begin
         cpar = ipar_ff[cur_ff];
         cisr = iisr_ff[cur_ff];
      end else begin
         cpar = lpar_ff[cur_ff];
         cisr = lisr_ff[cur_ff];
      end
   end
   assign at_root = ci_ff && (DW'(cur_ff) + 2'd2 == dist_ff);

   logic [COUNT_BITS-1:0] fsel;
   assign fsel = cnt_ff[sel_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff   <= ST_COUNT;
         dist_ff <= '0;
         ovf_ff  <= 1'b0;
         ov_ff   <= 1'b0;
      end else begin
         ov_ff <= ov_in;
         unique case (st_ff)
            // Count one request
            ST_COUNT: begin
               if (q_valid) begin
                  if (hit) begin
                     if (cnt_ff[hit_idx] != CMAX) cnt_ff[hit_idx] <= cnt_ff[hit_idx] + 1'b1;
                  end else if (dist_ff < DW'(MAX_SYMBOLS)) begin
                     sym_ff[dist_ff[SW-1:0]] <= q_item.symbol;
                     cnt_ff[dist_ff[SW-1:0]] <= COUNT_BITS'(1);
                  end
                  if (!hit && dist_ff < DW'(MAX_SYMBOLS)) dist_ff <= dist_ff + 1'b1;
                  if (!hit && dist_ff == DW'(MAX_SYMBOLS)) ovf_ff <= 1'b1;
                  if (q_item.last) st_ff <= ST_LOAD;
               end
            end
            // Free all nodes
            ST_LOAD: begin
               lused_ff <= '0;
               iused_ff <= '0;
               nxt_ff  <= '0;
               sint_ff <= 1'b0;
               idx_ff  <= '0;
               ha_ff   <= 1'b0;
               hb_ff   <= 1'b0;
               sel_ff  <= '0;
               if (dist_ff == '0) begin
                  st_ff <= ST_DONE;
               end else if (dist_ff == DW'(1)) begin
                  cur_ff  <= '0;
                  ci_ff   <= 1'b0;
                  code_ff <= '0;
                  len_ff  <= '0;
                  st_ff   <= ST_EMIT;
               end else begin
                  st_ff <= ST_SCAN;
               end
            end
            // Scan leaves, then joined nodes, one per cycle for the two smallest
            ST_SCAN: begin
               if (sfree) begin
                  if (!ha_ff || swt < aw_ff) begin
                     b_ff <= a_ff; bi_ff <= ai_ff; bw_ff <= aw_ff; hb_ff <= ha_ff;
                     a_ff <= idx_ff; ai_ff <= sint_ff; aw_ff <= swt; ha_ff <= 1'b1;
                  end else if (!hb_ff || swt < bw_ff) begin
                     b_ff <= idx_ff; bi_ff <= sint_ff; bw_ff <= swt; hb_ff <= 1'b1;
                  end
               end
               if ((leaf_end && nxt_ff == '0) || int_end) st_ff <= ST_JOIN;
               if (leaf_end) begin
                  sint_ff <= 1'b1;
                  idx_ff  <= '0;
               end else begin
                  idx_ff <= idx_ff + 1'b1;
               end
            end
            // Join the pair into a new node
            ST_JOIN: begin
               iwt_ff[nxt_ff] <= aw_ff + bw_ff;
               if (ai_ff) begin
                  ipar_ff[a_ff]  <= nxt_ff;
                  iisr_ff[a_ff]  <= 1'b0;
                  iused_ff[a_ff] <= 1'b1;
               end else begin
                  lpar_ff[a_ff]  <= nxt_ff;
                  lisr_ff[a_ff]  <= 1'b0;
                  lused_ff[a_ff] <= 1'b1;
               end
               if (bi_ff) begin
                  ipar_ff[b_ff]  <= nxt_ff;
                  iisr_ff[b_ff]  <= 1'b1;
                  iused_ff[b_ff] <= 1'b1;
               end else begin
                  lpar_ff[b_ff]  <= nxt_ff;
                  lisr_ff[b_ff]  <= 1'b1;
                  lused_ff[b_ff] <= 1'b1;
               end
               ha_ff   <= 1'b0;
               hb_ff   <= 1'b0;
               sint_ff <= 1'b0;
               idx_ff  <= '0;
               nxt_ff  <= nxt_ff + 1'b1;
               if (DW'(nxt_ff) + 2'd2 == dist_ff) begin
                  cur_ff  <= '0;
                  ci_ff   <= 1'b0;
                  code_ff <= '0;
                  len_ff  <= '0;
                  st_ff   <= ST_WALK;
               end else begin
                  st_ff <= ST_SCAN;
               end
            end
            // Climb one level per cycle
            ST_WALK: begin
               if (at_root) begin
                  st_ff <= ST_EMIT;
               end else begin
                  if (cisr && len_ff < 6'd31)
                     code_ff <= code_ff | (hcb_pkg::CODE_W'(1) << len_ff[4:0]);
                  len_ff <= len_ff + 1'b1;
                  cur_ff <= cpar;
                  ci_ff  <= 1'b1;
               end
            end
            // Load the output register
            ST_EMIT: begin
               if (out_free) begin
                  o_sym_ff  <= sym_ff[sel_ff];
                  o_frq_ff  <= (COUNT_BITS > 16 && (fsel >> 16) != '0) ? '1 :
                               hcb_pkg::FREQ_W'(fsel);
                  o_code_ff <= code_ff;
                  o_len_ff  <= len_ff[4:0];
                  o_full_ff <= ovf_ff;
                  o_last_ff <= (DW'(sel_ff) + 1'b1 == dist_ff);
                  if (DW'(sel_ff) + 1'b1 == dist_ff) begin
                     st_ff <= ST_DONE;
                  end else begin
                     sel_ff  <= sel_ff + 1'b1;
                     cur_ff  <= sel_ff + 1'b1;
                     ci_ff   <= 1'b0;
                     code_ff <= '0;
                     len_ff  <= '0;
                     st_ff   <= (dist_ff == DW'(1)) ? ST_EMIT : ST_WALK;
                  end
               end
            end
            // Close the run
            ST_DONE: begin
               dist_ff <= '0;
               ovf_ff  <= 1'b0;
               st_ff   <= ST_COUNT;
            end
            default: st_ff <= ST_COUNT;
         endcase
      end
   end
endmodule

@@ tb/sv/huffman_code_checker.sv @@
`timescale 1ns / 1ps

module huffman_code_checker #(
   parameter int MAX_SYMBOLS = hcb_pkg::MAX_SYMBOLS_DEF,
   parameter int COUNT_BITS  = hcb_pkg::COUNT_BITS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic                       req_stall,
   input  logic [hcb_pkg::SYM_W-1:0]  req_symbol,
   input  logic                       req_last,
   input  logic                       rsp_valid,
   input  logic                       rsp_stall,
   input  logic [hcb_pkg::SYM_W-1:0]  rsp_code_symbol,
   input  logic [hcb_pkg::FREQ_W-1:0] rsp_frequency,
   input  logic [hcb_pkg::CODE_W-1:0] rsp_code_bits,
   input  logic [hcb_pkg::LEN_W-1:0]  rsp_code_length,
   input  logic                       rsp_table_full,
   input  logic                       rsp_last_code,
   output int                         codes_pending,
   output int                         error_count
);
   localparam int NODES = 2 * MAX_SYMBOLS - 1;

   typedef struct {
      logic [hcb_pkg::SYM_W-1:0]  sym;
      logic [hcb_pkg::FREQ_W-1:0] freq;
      logic [hcb_pkg::CODE_W-1:0] bits;
      logic [hcb_pkg::LEN_W-1:0]  len;
      logic                       full;
      logic                       fin;
   } code_rec_type;

   code_rec_type code_q[$];

   logic [hcb_pkg::SYM_W-1:0] sym_tab[MAX_SYMBOLS];
   logic [COUNT_BITS-1:0]     cnt_tab[MAX_SYMBOLS];
   int                        distinct;
   logic                      dropped;
   longint                    weight[NODES];
   int                        parent[NODES];
   int                        left_of[NODES];

   task automatic report(input string what, input int got, input int want);
      error_count++;
      if (error_count <= 40)
         $display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, want);
   endtask

   // Lowest free node below range, skipping one; ties go to the lowest index
   function automatic int lightest(input int range, input int skip);
      int best;
      best = -1;
      for (int j = 0; j < range; j++) begin
         if (parent[j] != 0 || j == skip) continue;
         if (best < 0 || weight[j] < weight[best]) best = j;
      end
      return best;
   endfunction

   // Count one request; on last, build the tree and queue one code per symbol
   task automatic tally_request(input logic [hcb_pkg::SYM_W-1:0] s, input logic fin);
      int hit, a, b, c, f, len;
      logic [63:0] code;
      code_rec_type rec;
      hit = -1;
      for (int j = 0; j < distinct; j++)
         if (sym_tab[j] == s) hit = j;
      if (hit >= 0) begin
         if (cnt_tab[hit] != '1) cnt_tab[hit]++;
      end else if (distinct < MAX_SYMBOLS) begin
         sym_tab[distinct] = s;
         cnt_tab[distinct] = 1;
         distinct++;
      end else begin
         dropped = 1'b1;
      end
      if (!fin) return;

      if (distinct > 1) begin
         for (int j = 0; j < 2 * distinct - 1; j++) begin
            parent[j] = 0;
            left_of[j] = 0;
         end
         for (int j = 0; j < distinct; j++) weight[j] = cnt_tab[j];
         for (int j = distinct; j < 2 * distinct - 1; j++) begin
            a = lightest(j, -1);
            b = lightest(j, a);
            parent[a] = j;
            parent[b] = j;
            left_of[j] = a;
            weight[j] = weight[a] + weight[b];
         end
      end
      for (int j = 0; j < distinct; j++) begin
         code = '0;
         len = 0;
         if (distinct > 1) begin
            c = j;
            f = parent[c];
            while (f != 0 && len < 63) begin
               if (c != left_of[f]) code[len] = 1'b1;
               len++;
               c = f;
               f = parent[f];
            end
         end
         rec.sym  = sym_tab[j];
         rec.freq = (cnt_tab[j] > 65535) ? 16'hFFFF : hcb_pkg::FREQ_W'(cnt_tab[j]);
         rec.bits = code[hcb_pkg::CODE_W-1:0];
         rec.len  = hcb_pkg::LEN_W'(len);
         rec.full = dropped;
         rec.fin  = (j == distinct - 1);
         code_q.push_back(rec);
      end
      distinct = 0;
      dropped = 1'b0;
   endtask

   initial begin
      error_count = 0;
      codes_pending = 0;
      distinct = 0;
      dropped = 1'b0;
   end

   // Watch both channels at each edge
   always @(posedge clock) begin
      code_rec_type want;
      if (!reset) begin
         if (req_valid && !req_stall) tally_request(req_symbol, req_last);
         if (rsp_valid && !rsp_stall) begin
            if (code_q.size() == 0) begin
               report("unexpected code result, symbol", rsp_code_symbol, -1);
            end else begin
               want = code_q.pop_front();
               if (rsp_code_symbol !== want.sym)
                  report("code_symbol", rsp_code_symbol, want.sym);
               if (rsp_frequency !== want.freq)
                  report("frequency", rsp_frequency, want.freq);
               if (rsp_code_bits !== want.bits)
                  report("code_bits", rsp_code_bits, want.bits);
               if (rsp_code_length !== want.len)
                  report("code_length", rsp_code_length, want.len);
               if (rsp_table_full !== want.full)
                  report("table_full", rsp_table_full, want.full);
               if (rsp_last_code !== want.fin)
                  report("last_code", rsp_last_code, want.fin);
            end
         end
      end
      codes_pending = code_q.size();
   end

endmodule

@@ tb/sv/tb_huffman_code_builder_unit.sv @@
`timescale 1ns / 1ps

module tb_huffman_code_builder_unit;

   localparam int CYCLE_LIMIT = 500000;

   logic                       clock;
   logic                       reset;
   logic                       req_valid;
   logic                       req_stall;
   logic [hcb_pkg::SYM_W-1:0]  req_symbol;
   logic                       req_last;
   logic                       rsp_valid;
   logic                       rsp_stall;
   logic [hcb_pkg::SYM_W-1:0]  rsp_code_symbol;
   logic [hcb_pkg::FREQ_W-1:0] rsp_frequency;
   logic [hcb_pkg::CODE_W-1:0] rsp_code_bits;
   logic [hcb_pkg::LEN_W-1:0]  rsp_code_length;
   logic                       rsp_table_full;
   logic                       rsp_last_code;
   int                         codes_pending;
   int                         error_count;
   int                         cycles;
   logic                       quiet;

   huffman_code_builder_unit dut (.*);
   huffman_code_checker checker_i (.*);

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Abort a hung run
   initial cycles = 0;
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // Stall results at random outside the quiet stretch
   always @(posedge clock)
      rsp_stall <= !quiet && ($urandom_range(99) < 28);

   // Drive one request and hold it until accepted
   task automatic send_request(input logic [hcb_pkg::SYM_W-1:0] s, input logic fin);
      while (!quiet && $urandom_range(99) < 28) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_symbol <= s;
      req_last   <= fin;
      @(negedge clock);
      while (req_stall) @(negedge clock);
      @(posedge clock);
   endtask

   initial begin
      int sent, runs, alpha_n, run_len;
      logic [hcb_pkg::SYM_W-1:0] alpha[40];
      reset = 1'b1;
      quiet = 1'b0;
      req_valid = 1'b0;
      req_symbol = '0;
      req_last = 1'b0;
      rsp_stall = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Lone symbol runs at both extremes
      send_request(8'h00, 1'b1);
      send_request(8'hFF, 1'b0);
      send_request(8'hFF, 1'b1);
      // Two symbols with a tie, then overflow the table
      send_request(8'hAA, 1'b0);
      send_request(8'h55, 1'b1);
      for (int j = 0; j < 36; j++) send_request(8'(j * 7 + 1), 1'b0);
      send_request(8'h01, 1'b0);
      send_request(8'hC3, 1'b1);
      // Skewed counts for deep codes
      begin
         int fa, fb, ft;
         fa = 1;
         fb = 1;
         for (int j = 0; j < 10; j++) begin
            for (int k = 0; k < fa; k++) send_request(8'(8'h80 + j), 1'b0);
            ft = fa + fb;
            fa = fb;
            fb = ft;
         end
         send_request(8'h80, 1'b1);
      end

      // Random runs over random alphabets, sometimes wider than the table
      sent = 0;
      runs = 0;
      while (sent < 235) begin
         alpha_n = $urandom_range(40, 1);
         for (int j = 0; j < alpha_n; j++) alpha[j] = 8'($urandom_range(255));
         run_len = ($urandom_range(9) == 0) ? $urandom_range(60, 35) : $urandom_range(30, 1);
         quiet = (sent > 60 && sent < 160);
         for (int j = 0; j < run_len; j++) begin
            send_request(alpha[$urandom_range(alpha_n - 1)], j == run_len - 1);
            sent++;
         end
         runs++;
         // Hold off until every code has drained
         if (runs == 5) begin
            req_valid <= 1'b0;
            @(posedge clock);
            while (codes_pending != 0) @(posedge clock);
         end
      end
      quiet = 1'b0;
      req_valid <= 1'b0;

      @(posedge clock);
      while (codes_pending != 0) @(posedge clock);
      repeat (4000) @(posedge clock);
      if (error_count == 0 && codes_pending == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
